// File: hw/rtl/rotenc_pkg.sv
// Shared types and constants for the rotary encoder counter.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package rotenc_pkg;

  // Width of the saturating elapsed tick counters.
  localparam int unsigned ElapsedBits = 16;
  // Width of the lockout registers.
  localparam int unsigned LockBits    = 16;
  // Width of the signed step count.
  localparam int unsigned CountBits   = 8;
  // Width of the configuration register index.
  localparam int unsigned CfgIdxBits  = 2;

  // Comparison width that holds both an elapsed count and a lockout.
  localparam int unsigned CmpBits = (ElapsedBits > LockBits) ? ElapsedBits : LockBits;

  localparam logic [ElapsedBits-1:0] ElapsedMax = {ElapsedBits{1'b1}};

  localparam logic [LockBits-1:0] RotLockoutReset = LockBits'(2);
  localparam logic [LockBits-1:0] KeyLockoutReset = LockBits'(50);

  typedef enum logic [CfgIdxBits-1:0] {
    CfgRotLockout = 2'd0,
    CfgKeyLockout = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [LockBits-1:0] rot_lockout;
    logic [LockBits-1:0] key_lockout;
  } cfg_t;

  typedef struct packed {
    logic phase_a_level;
    logic phase_b_level;
    logic key_level;
    logic read_rotation;
    logic read_key;
  } item_t;

  typedef struct packed {
    logic signed [CountBits-1:0] rotation_value;
    logic                        key_pressed;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/rotenc_cfg.sv
// Configuration register file for the rotary encoder counter.
// Holds the rotation and key lockouts; depends on rotenc_pkg.
`default_nettype none

module rotenc_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [rotenc_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  wire logic [rotenc_pkg::LockBits-1:0]  cfg_data_i,
  output rotenc_pkg::cfg_t                      cfg_o
);
  import rotenc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgRotLockout: cfg_d.rot_lockout = cfg_data_i;
        CfgKeyLockout: cfg_d.key_lockout = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot_lockout <= RotLockoutReset;
      cfg_q.key_lockout <= KeyLockoutReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/rotenc_core.sv
// Per-tick decoder state and update logic: edge detection, lockout
// timing, step count and sticky key flag. Depends on rotenc_pkg.
`default_nettype none

module rotenc_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_en_i,
  input  rotenc_pkg::item_t      item_i,
  input  rotenc_pkg::cfg_t       cfg_i,
  output rotenc_pkg::result_t    result_o
);
  import rotenc_pkg::*;

  logic signed [CountBits-1:0] count_q, count_d;
  logic                        flag_q, flag_d;
  logic [ElapsedBits-1:0]      rot_ticks_q, rot_ticks_d;
  logic [ElapsedBits-1:0]      key_ticks_q, key_ticks_d;
  logic                        prev_a_q, prev_key_q;

  logic [ElapsedBits-1:0]      rot_adv, key_adv;
  logic                        rot_edge, key_edge;
  logic signed [CountBits-1:0] count_base;
  logic                        flag_base;

  // Saturating advance of both elapsed counters.
  assign rot_adv = (rot_ticks_q == ElapsedMax) ? rot_ticks_q : rot_ticks_q + 1'b1;
  assign key_adv = (key_ticks_q == ElapsedMax) ? key_ticks_q : key_ticks_q + 1'b1;

  assign rot_edge = prev_a_q && !item_i.phase_a_level &&
                    (CmpBits'(rot_adv) >= CmpBits'(cfg_i.rot_lockout));
  assign key_edge = prev_key_q && !item_i.key_level &&
                    (CmpBits'(key_adv) > CmpBits'(cfg_i.key_lockout));

  // A read clears the stored value before this tick's update lands.
  assign count_base = item_i.read_rotation ? '0 : count_q;
  assign flag_base  = item_i.read_key ? 1'b0 : flag_q;

  always_comb begin
    count_d = count_base;
    if (rot_edge) begin
      count_d = item_i.phase_b_level ? count_base + 1'b1 : count_base - 1'b1;
    end
  end

  assign flag_d      = key_edge ? 1'b1 : flag_base;
  assign rot_ticks_d = rot_edge ? '0 : rot_adv;
  assign key_ticks_d = key_edge ? '0 : key_adv;

  assign result_o.rotation_value = item_i.read_rotation ? count_q : '0;
  assign result_o.key_pressed    = item_i.read_key ? flag_q : 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      flag_q      <= 1'b0;
      rot_ticks_q <= '0;
      key_ticks_q <= '0;
      prev_a_q    <= 1'b1;
      prev_key_q  <= 1'b1;
    end else if (step_en_i) begin
      count_q     <= count_d;
      flag_q      <= flag_d;
      rot_ticks_q <= rot_ticks_d;
      key_ticks_q <= key_ticks_d;
      prev_a_q    <= item_i.phase_a_level;
      prev_key_q  <= item_i.key_level;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rotary_encoder_debounced_counter.sv
// Rotary encoder decoder with debounced push key: top level with the
// input and result registers. Depends on rotenc_pkg, rotenc_cfg, rotenc_core.
//
// Usage. Each input item is one timebase tick: the sampled levels of encoder
// phase A, phase B and the key pin, plus the two read strobes. An item is
// taken at a rising edge with in_valid_i high and in_stall_o low, and every
// item yields exactly one result item (rotation_value_o, key_pressed_o),
// handed over at an edge with out_valid_o high and out_stall_i low.
// Each item is captured in the input register; the decoder state is then
// updated and the result is captured in the result register. The block takes
// one item per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its item and the input
// register can still take one more item; only when both are full does
// in_stall_o rise. Configuration writes (index 0 rotation lockout, index 1
// key lockout, other indexes ignored) are always ready and should be issued
// while no item is in flight.
// Reset clears the count, the key flag and both elapsed counters, sets the
// remembered pin levels high (pull-ups) and restores the lockouts to 2 and 50.
`default_nettype none

module rotary_encoder_debounced_counter (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Tick input channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              phase_a_level_i,
  input  wire logic                              phase_b_level_i,
  input  wire logic                              key_level_i,
  input  wire logic                              read_rotation_i,
  input  wire logic                              read_key_i,
  // Result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [rotenc_pkg::CountBits-1:0] rotation_value_o,
  output logic                                   key_pressed_o,
  // Configuration write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [rotenc_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  wire logic [rotenc_pkg::LockBits-1:0]   cfg_data_i
);
  import rotenc_pkg::*;

  cfg_t    cfg;
  item_t   in_item_q;
  logic    in_valid_q;
  result_t core_result;
  result_t out_result_q;
  logic    out_valid_q;

  logic    out_free;
  logic    step_en;
  logic    in_take;

  // The result register can take a new item when empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;
  // The held item moves into the decoder when the result register is free.
  assign step_en    = in_valid_q && out_free;
  // The input register refills when empty or emptying this cycle.
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  rotenc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rotenc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .item_i    (in_item_q),
    .cfg_i     (cfg),
    .result_o  (core_result)
  );

  // Input register: control bit is reset, payload is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_valid_q || out_free) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.phase_a_level <= phase_a_level_i;
      in_item_q.phase_b_level <= phase_b_level_i;
      in_item_q.key_level     <= key_level_i;
      in_item_q.read_rotation <= read_rotation_i;
      in_item_q.read_key      <= read_key_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      out_result_q <= core_result;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign rotation_value_o = out_result_q.rotation_value;
  assign key_pressed_o    = out_result_q.key_pressed;

endmodule

`default_nettype wire

// File: hw/rtl/rotenc_checker.sv
// Port-level checks for the rotary encoder counter, bound to the top level.
// Depends on rotenc_pkg and rotary_encoder_debounced_counter.
`default_nettype none

module rotenc_checker (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  input  wire logic                              in_stall_o,
  input  wire logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  input  wire logic [rotenc_pkg::CountBits-1:0]  rotation_value_o,
  input  wire logic                              key_pressed_o
);
  import rotenc_pkg::*;

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(rotation_value_o) && $stable(key_pressed_o))
    else $error("stalled result changed");

  // Back-pressure only appears when a result is waiting and stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // An accepted item passes through the input register into the result register
  // when the receiver does not stall in between.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o ##1 !out_stall_i |=> out_valid_o)
    else $error("result missing after accepted item");

endmodule

bind rotary_encoder_debounced_counter rotenc_checker u_rotenc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .rotation_value_o (rotation_value_o),
  .key_pressed_o    (key_pressed_o)
);

`default_nettype wire

// File: verif/rotary_encoder_debounced_counter_checker.sv
// Checker for the rotary encoder counter: watches the tick, result and register channels,
// predicts each result and compares it with what the block returns.
// Depends on rotenc_pkg for the item and result types and the reset lockouts.

module rotary_encoder_debounced_counter_checker
  import rotenc_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic                        in_stall_i,
  input  wire logic                        phase_a_level_i,
  input  wire logic                        phase_b_level_i,
  input  wire logic                        key_level_i,
  input  wire logic                        read_rotation_i,
  input  wire logic                        read_key_i,
  input  wire logic                        out_valid_i,
  input  wire logic                        out_stall_i,
  input  wire logic signed [CountBits-1:0] rotation_value_i,
  input  wire logic                        key_pressed_i,
  input  wire logic                        cfg_valid_i,
  input  wire logic                        cfg_ready_i,
  input  wire logic [CfgIdxBits-1:0]       cfg_index_i,
  input  wire logic [LockBits-1:0]         cfg_data_i,
  output int                               errors_o,
  output int                               pending_o
);

  logic [LockBits-1:0]    rot_lock_q;
  logic [LockBits-1:0]    key_lock_q;
  logic [CountBits-1:0]   steps_q;
  logic                   pressed_q;
  logic [ElapsedBits-1:0] rot_ticks_q;
  logic [ElapsedBits-1:0] key_ticks_q;
  logic                   last_a_q;
  logic                   last_key_q;
  result_t                expected_q[$];
  int                     fault_count;

  task automatic flag_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  // Reads see the stored values first; the edge updates then land on the cleared state.
  function automatic result_t decode_tick(input item_t tick);
    result_t                res;
    logic [ElapsedBits-1:0] rot_adv;
    logic [ElapsedBits-1:0] key_adv;
    res.rotation_value = tick.read_rotation ? steps_q : '0;
    res.key_pressed    = tick.read_key ? pressed_q : 1'b0;
    if (tick.read_rotation) steps_q = '0;
    if (tick.read_key) pressed_q = 1'b0;

    rot_adv = (rot_ticks_q == ElapsedMax) ? ElapsedMax : rot_ticks_q + 1'b1;
    key_adv = (key_ticks_q == ElapsedMax) ? ElapsedMax : key_ticks_q + 1'b1;

    if (last_a_q && !tick.phase_a_level && (CmpBits'(rot_adv) >= CmpBits'(rot_lock_q))) begin
      steps_q = tick.phase_b_level ? steps_q + 1'b1 : steps_q - 1'b1;
      rot_adv = '0;
    end
    if (last_key_q && !tick.key_level && (CmpBits'(key_adv) > CmpBits'(key_lock_q))) begin
      pressed_q = 1'b1;
      key_adv   = '0;
    end

    rot_ticks_q = rot_adv;
    key_ticks_q = key_adv;
    last_a_q    = tick.phase_a_level;
    last_key_q  = tick.key_level;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    item_t   tick;
    result_t want;
    if (!rst_ni) begin
      rot_lock_q  = RotLockoutReset;
      key_lock_q  = KeyLockoutReset;
      steps_q     = '0;
      pressed_q   = 1'b0;
      rot_ticks_q = '0;
      key_ticks_q = '0;
      last_a_q    = 1'b1;
      last_key_q  = 1'b1;
      expected_q.delete();
      fault_count = 0;
      errors_o   <= 0;
      pending_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgRotLockout: rot_lock_q = cfg_data_i;
          CfgKeyLockout: key_lock_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        tick.phase_a_level = phase_a_level_i;
        tick.phase_b_level = phase_b_level_i;
        tick.key_level     = key_level_i;
        tick.read_rotation = read_rotation_i;
        tick.read_key      = read_key_i;
        expected_q.push_back(decode_tick(tick));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          flag_fault($sformatf("result with none outstanding: rotation %0d key %b",
                               rotation_value_i, key_pressed_i));
        end else begin
          want = expected_q.pop_front();
          if (rotation_value_i !== want.rotation_value) begin
            flag_fault($sformatf("rotation value expected %0d got %0d",
                                 want.rotation_value, rotation_value_i));
          end
          if (key_pressed_i !== want.key_pressed) begin
            flag_fault($sformatf("key pressed expected %b got %b",
                                 want.key_pressed, key_pressed_i));
          end
        end
      end
      errors_o  <= fault_count;
      pending_o <= expected_q.size();
    end
  end

endmodule

// File: verif/rotary_encoder_debounced_counter_tb.sv
// Top of the rotary encoder counter testbench: clock, reset, tick stimulus, result stalls
// and register writes. Depends on rotenc_pkg, the block and the checker module.

module rotary_encoder_debounced_counter_tb;
  import rotenc_pkg::*;

  // An index that names no register; writes to it must leave both lockouts alone.
  localparam logic [CfgIdxBits-1:0] CfgIdxUnused = 2'd3;
  // Cycles the receiver holds off when asked to, long enough to fill both registers.
  localparam int HoldOffCycles = 40;
  // Settling allowed after the last result has come back, before a register write.
  localparam int SettleCycles  = 4;

  typedef enum int {StallNone, StallLight, StallHeavy, StallToggle} stall_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                    tick_valid = 1'b0;
  logic                    a_pin      = 1'b1;
  logic                    b_pin      = 1'b0;
  logic                    key_pin    = 1'b1;
  logic                    rd_rot     = 1'b0;
  logic                    rd_key     = 1'b0;
  logic                    res_stall  = 1'b0;
  logic                    reg_valid  = 1'b0;
  logic [CfgIdxBits-1:0]   reg_index  = '0;
  logic [LockBits-1:0]     reg_data   = '0;

  logic                    in_stall_o;
  logic                    out_valid_o;
  logic signed [CountBits-1:0] rotation_value_o;
  logic                    key_pressed_o;
  logic                    cfg_ready_o;

  int mismatches;
  int results_due;

  // Pin levels carried from one tick to the next, so that edges come from real transitions.
  logic a_lvl   = 1'b1;
  logic b_lvl   = 1'b0;
  logic k_lvl   = 1'b1;
  logic fwd     = 1'b1;
  // Sender pacing: items go out in bursts; with steady set, no gaps are left at all.
  int   burst_left;
  bit   steady;
  // Each increment asks the receiver for one long hold-off.
  int   hold_requests;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rotary_encoder_debounced_counter i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (tick_valid),
    .in_stall_o       (in_stall_o),
    .phase_a_level_i  (a_pin),
    .phase_b_level_i  (b_pin),
    .key_level_i      (key_pin),
    .read_rotation_i  (rd_rot),
    .read_key_i       (rd_key),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (res_stall),
    .rotation_value_o (rotation_value_o),
    .key_pressed_o    (key_pressed_o),
    .cfg_valid_i      (reg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (reg_index),
    .cfg_data_i       (reg_data)
  );

  rotary_encoder_debounced_counter_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (tick_valid),
    .in_stall_i       (in_stall_o),
    .phase_a_level_i  (a_pin),
    .phase_b_level_i  (b_pin),
    .key_level_i      (key_pin),
    .read_rotation_i  (rd_rot),
    .read_key_i       (rd_key),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (res_stall),
    .rotation_value_i (rotation_value_o),
    .key_pressed_i    (key_pressed_o),
    .cfg_valid_i      (reg_valid),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (reg_index),
    .cfg_data_i       (reg_data),
    .errors_o         (mismatches),
    .pending_o        (results_due)
  );

  // Offers one tick and returns at the edge where it is taken. Valid stays high from one
  // item to the next inside a burst; between bursts it drops for a random gap, which may
  // also be empty. The gap is decided before the item is offered, never on the stall.
  task automatic send_tick(input logic a, input logic b, input logic k,
                           input logic rr, input logic rk);
    int gap;
    if (!steady && burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        tick_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 60);
    end
    tick_valid <= 1'b1;
    a_pin      <= a;
    b_pin      <= b;
    key_pin    <= k;
    rd_rot     <= rr;
    rd_key     <= rk;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
  endtask

  // Stops offering and waits until every result has come back, then lets the block settle.
  // The first edge is needed because the outstanding count is a registered value.
  task automatic drain();
    tick_valid <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register writes are only issued with the block drained. The closing edge keeps the
  // next write from driving valid again in the same time step.
  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [LockBits-1:0] value);
    reg_valid <= 1'b1;
    reg_index <= idx;
    reg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    reg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly well-formed encoder and key activity: phase A toggles after random holds around
  // the lockout, phase B follows the turning direction at each falling edge, and the key
  // is pressed and released with random holds. Some ticks are pure noise instead.
  task automatic run_ticks(input int count, input int rot_span, input int key_span,
                           input int read_pct, input int noise_pct, input int turn_pct);
    int a_hold;
    int k_hold;
    a_hold = 0;
    k_hold = 0;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else begin
        if (a_hold == 0) begin
          a_lvl  = ~a_lvl;
          a_hold = $urandom_range(0, rot_span);
          if (!a_lvl) begin
            if ($urandom_range(0, 99) < turn_pct) fwd = ~fwd;
            b_lvl = fwd;
          end
        end else begin
          a_hold--;
        end
        if (k_hold == 0) begin
          k_lvl  = ~k_lvl;
          k_hold = $urandom_range(0, key_span);
        end else begin
          k_hold--;
        end
        send_tick(a_lvl, b_lvl, k_lvl,
                  $urandom_range(0, 99) < read_pct, $urandom_range(0, 99) < read_pct);
      end
    end
    drain();
  endtask

  // The receiver runs its own stall pattern, switching between modes after random stretches,
  // one of which never stalls. A pending hold-off request overrides the pattern and keeps
  // the result side stalled for one long hold-off while the sender goes on offering.
  initial begin
    stall_mode_e mode;
    int          span;
    int          served;
    int          hold_left;
    served    = 0;
    hold_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      span = $urandom_range(10, 120);
      repeat (span) begin
        @(posedge clk_i);
        if (hold_left == 0 && hold_requests != served) begin
          served++;
          hold_left = HoldOffCycles;
        end
        if (hold_left > 0) begin
          hold_left--;
          res_stall <= 1'b1;
        end else begin
          case (mode)
            StallNone:  res_stall <= 1'b0;
            StallLight: res_stall <= ($urandom_range(0, 3) == 0);
            StallHeavy: res_stall <= ($urandom_range(0, 3) != 0);
            default:    res_stall <= ~res_stall;
          endcase
        end
      end
    end
  end

  initial begin
    int rot_lock;
    int key_lock;
    burst_left    = 0;
    steady        = 1'b0;
    hold_requests = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset lockouts of 2 and 50. An A edge on the first tick after
    // reset is rejected, as the elapsed count has only reached one; so is a key press.
    send_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
    drain();

    // With both lockouts at zero every edge counts. Reads on the same tick as an edge
    // must return the old value, and the register then takes the new step or press.
    write_reg(CfgRotLockout, '0);
    write_reg(CfgKeyLockout, '0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    drain();

    // A write to an unused index must change nothing; the lockouts stay at zero.
    write_reg(CfgIdxUnused, 16'h0005);
    hold_requests++;
    run_ticks(100, 4, 6, 10, 20, 15);

    write_reg(CfgRotLockout, 16'd1);
    write_reg(CfgKeyLockout, 16'd1);
    run_ticks(100, 3, 5, 10, 15, 15);

    write_reg(CfgRotLockout, 16'd3);
    write_reg(CfgKeyLockout, 16'd7);
    run_ticks(100, 6, 12, 10, 15, 15);

    // Long runs in one direction with no reads, to wrap the count both ways.
    write_reg(CfgRotLockout, '0);
    write_reg(CfgKeyLockout, '0);
    send_tick(a_lvl, b_lvl, k_lvl, 1'b1, 1'b0);
    run_ticks(300, 0, 6, 0, 0, 0);
    send_tick(a_lvl, b_lvl, k_lvl, 1'b1, 1'b0);
    fwd = ~fwd;
    run_ticks(300, 0, 6, 0, 0, 0);

    // Random lockouts, with spans chosen so that edges land on both sides of the limit.
    repeat (2) begin
      rot_lock = $urandom_range(0, 8);
      key_lock = $urandom_range(0, 60);
      write_reg(CfgRotLockout, LockBits'(rot_lock));
      write_reg(CfgKeyLockout, LockBits'(key_lock));
      hold_requests++;
      run_ticks(100, rot_lock + 3, key_lock / 2 + 4, 10, 15, 15);
    end

    if (mismatches == 0 && results_due == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Generous bound on the whole run; the slowest correct run is well under a tenth of it.
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
